// File: hdl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// Pareto front archive package
// Shared constants and types; the dominance test is in pfa_back.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int unsigned Capacity = 32;
  localparam int unsigned ObjWidth = 32;
  localparam int unsigned FieldWidth = 32;
  localparam int unsigned TagWidth = 16;
  localparam int unsigned CountWidth = 6;
  localparam int unsigned QueueDepth = 2;

  localparam logic [0:0] RegMaximizeA = 1'b0;
  localparam logic [0:0] RegMaximizeB = 1'b1;

  localparam logic KindStatus = 1'b0;
  localparam logic KindEntry = 1'b1;

  typedef struct packed {
    logic [FieldWidth-1:0] obj_a;
    logic [FieldWidth-1:0] obj_b;
    logic [TagWidth-1:0] tag;
    logic last_item;
  } cand_t;

endpackage

// File: hdl/pfa_front.sv
// ----------------------------------------------------------------------------
// Pareto front archive: front end
// Accepts candidates, masks objectives and feeds a short queue.
// ----------------------------------------------------------------------------
module pfa_front #(
  parameter int unsigned ObjWidth = pfa_pkg::ObjWidth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic [pfa_pkg::FieldWidth-1:0] obj_a_i,
  input  logic [pfa_pkg::FieldWidth-1:0] obj_b_i,
  input  logic [pfa_pkg::TagWidth-1:0] tag_i,
  input  logic last_item_i,
  output logic q_valid_o,
  input  logic q_pop_i,
  output pfa_pkg::cand_t q_data_o
);
  localparam int unsigned D = pfa_pkg::QueueDepth;
  localparam logic [pfa_pkg::FieldWidth-1:0] Mask =
    pfa_pkg::FieldWidth'((65'(1) << ObjWidth) - 65'(1));

  pfa_pkg::cand_t mem_q [D];
  logic [0:0] wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic push;

  assign in_stall_o = (cnt_q == 2'(D));
  assign push = in_valid_i && !in_stall_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o = mem_q[rd_q];

  always_comb begin
    wr_d = push ? wr_q + 1'b1 : wr_q;
    rd_d = q_pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + 2'(push) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{obj_a: obj_a_i & Mask, obj_b: obj_b_i & Mask,
                       tag: tag_i, last_item: last_item_i};
    end
  end
endmodule

// File: hdl/pfa_back.sv
// ----------------------------------------------------------------------------
// Pareto front archive: back end
// Scans the archive, compacts survivors, appends and dumps the front.
// ----------------------------------------------------------------------------
module pfa_back #(
  parameter int unsigned Capacity = pfa_pkg::Capacity
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic max_a_i,
  input  logic max_b_i,
  input  logic q_valid_i,
  output logic q_pop_o,
  input  pfa_pkg::cand_t q_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic kind_o,
  output logic accepted_o,
  output logic overflow_o,
  output logic [pfa_pkg::CountWidth-1:0] front_count_o,
  output logic [pfa_pkg::FieldWidth-1:0] entry_obj_a_o,
  output logic [pfa_pkg::FieldWidth-1:0] entry_obj_b_o,
  output logic [pfa_pkg::TagWidth-1:0] entry_tag_o,
  output logic last_of_run_o
);
  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned CW = pfa_pkg::CountWidth;
  localparam int unsigned FW = pfa_pkg::FieldWidth;
  localparam int unsigned TW = pfa_pkg::TagWidth;
  localparam logic [CW-1:0] Cap = CW'(Capacity);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;  // dominance check, read pipelined
  localparam logic [2:0] StComp = 3'd2;  // compaction
  localparam logic [2:0] StStat = 3'd3;
  localparam logic [2:0] StDump = 3'd4;

  logic [FW-1:0] mem_a [Capacity];
  logic [FW-1:0] mem_b [Capacity];
  logic [TW-1:0] mem_t [Capacity];

  logic [2:0] st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d, rd_q, rd_d, keep_q, keep_d;
  logic rv_q, rv_d;            // read data valid
  logic [CW-1:0] rix_q, rix_d; // index of read data
  logic [FW-1:0] ra_q, rb_q;
  logic [TW-1:0] rt_q;
  pfa_pkg::cand_t c_q, c_d;
  logic dom_q, dom_d;
  logic acc_q, acc_d, ovf_q, ovf_d;

  logic ov_q, ov_d, okind_q, okind_d, oacc_q, oacc_d, oovf_q, oovf_d, olast_q, olast_d;
  logic [CW-1:0] ocnt_q, ocnt_d;
  logic [FW-1:0] oa_q, oa_d, ob_q, ob_d;
  logic [TW-1:0] ot_q, ot_d;

  logic ren, wen;
  logic [AW-1:0] waddr;
  logic [FW-1:0] wa, wb;
  logic [TW-1:0] wt;
  logic out_free;
  logic s_dom_c, c_dom_s;

  assign out_free = !ov_q || !out_stall_i;
  assign s_dom_c = (max_a_i ? ra_q > c_q.obj_a : ra_q < c_q.obj_a)
                && (max_b_i ? rb_q > c_q.obj_b : rb_q < c_q.obj_b);
  assign c_dom_s = (max_a_i ? c_q.obj_a > ra_q : c_q.obj_a < ra_q)
                && (max_b_i ? c_q.obj_b > rb_q : c_q.obj_b < rb_q);

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; rd_d = rd_q; keep_d = keep_q;
    rv_d = 1'b0; rix_d = rd_q; c_d = c_q; dom_d = dom_q;
    acc_d = acc_q; ovf_d = ovf_q;
    ov_d = ov_q && out_stall_i;
    okind_d = okind_q; oacc_d = oacc_q; oovf_d = oovf_q; olast_d = olast_q;
    ocnt_d = ocnt_q; oa_d = oa_q; ob_d = ob_q; ot_d = ot_q;
    q_pop_o = 1'b0; ren = 1'b0; wen = 1'b0;
    waddr = keep_q[AW-1:0]; wa = ra_q; wb = rb_q; wt = rt_q;
    case (st_q)
      StIdle: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          c_d = q_data_i;
          dom_d = 1'b0;
          rd_d = '0;
          keep_d = '0;
          st_d = StScan;
        end
      end
      StScan: begin
        if (rv_q && s_dom_c) dom_d = 1'b1;
        if (rd_q < cnt_q && !(dom_q || (rv_q && s_dom_c))) begin
          ren = 1'b1;
          rv_d = 1'b1;
          rd_d = rd_q + 1'b1;
        end else if (!rv_q || !(rd_q < cnt_q) || s_dom_c) begin
          if (dom_q || (rv_q && s_dom_c)) begin
            acc_d = 1'b0; ovf_d = 1'b0;
            st_d = StStat;
          end else begin
            rd_d = '0;
            st_d = StComp;
          end
        end
      end
      StComp: begin
        if (rv_q && !c_dom_s) begin
          wen = 1'b1;
          keep_d = keep_q + 1'b1;
        end
        if (rd_q < cnt_q) begin
          ren = 1'b1;
          rv_d = 1'b1;
          rd_d = rd_q + 1'b1;
        end else if (!rv_q) begin
          if (keep_q < Cap) begin
            wen = 1'b1;
            wa = c_q.obj_a; wb = c_q.obj_b; wt = c_q.tag;
            cnt_d = keep_q + 1'b1;
            acc_d = 1'b1; ovf_d = 1'b0;
          end else begin
            cnt_d = keep_q;
            acc_d = 1'b0; ovf_d = 1'b1;
          end
          st_d = StStat;
        end
      end
      StStat: begin
        if (out_free) begin
          ov_d = 1'b1; okind_d = pfa_pkg::KindStatus;
          oacc_d = acc_q; oovf_d = ovf_q; ocnt_d = cnt_q;
          oa_d = '0; ob_d = '0; ot_d = '0;
          olast_d = !c_q.last_item || cnt_q == '0;
          rd_d = '0;
          if (c_q.last_item && cnt_q != '0) begin
            st_d = StDump;
          end else begin
            if (c_q.last_item) cnt_d = '0;
            st_d = StIdle;
          end
        end
      end
      StDump: begin
        // one entry in flight at most: read, then emit
        if (rv_q) begin
          if (out_free) begin
            ov_d = 1'b1; okind_d = pfa_pkg::KindEntry;
            oacc_d = 1'b0; oovf_d = 1'b0; ocnt_d = cnt_q;
            oa_d = ra_q; ob_d = rb_q; ot_d = rt_q;
            olast_d = (rix_q + 1'b1 == cnt_q);
            if (rix_q + 1'b1 == cnt_q) begin
              cnt_d = '0;
              st_d = StIdle;
            end
          end else begin
            rv_d = 1'b1;
            rix_d = rix_q;
          end
        end else if (rd_q < cnt_q) begin
          ren = 1'b1;
          rv_d = 1'b1;
          rd_d = rd_q + 1'b1;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      cnt_q <= '0;
      rv_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
      rv_q <= rv_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= rd_d; keep_q <= keep_d; rix_q <= rix_d; c_q <= c_d;
    dom_q <= dom_d; acc_q <= acc_d; ovf_q <= ovf_d;
    okind_q <= okind_d; oacc_q <= oacc_d; oovf_q <= oovf_d; olast_q <= olast_d;
    ocnt_q <= ocnt_d; oa_q <= oa_d; ob_q <= ob_d; ot_q <= ot_d;
  end

  always_ff @(posedge clk_i) begin
    if (ren) begin
      ra_q <= mem_a[rd_q[AW-1:0]];
      rb_q <= mem_b[rd_q[AW-1:0]];
      rt_q <= mem_t[rd_q[AW-1:0]];
    end
    if (wen) begin
      mem_a[waddr] <= wa;
      mem_b[waddr] <= wb;
      mem_t[waddr] <= wt;
    end
  end

  assign out_valid_o = ov_q;
  assign kind_o = okind_q;
  assign accepted_o = oacc_q;
  assign overflow_o = oovf_q;
  assign front_count_o = ocnt_q;
  assign entry_obj_a_o = oa_q;
  assign entry_obj_b_o = ob_q;
  assign entry_tag_o = ot_q;
  assign last_of_run_o = olast_q;
endmodule

// File: hdl/pareto_front_archive_core.sv
// ----------------------------------------------------------------------------
// Pareto front archive core
// Bi-objective archive of non-dominated solutions with front dump.
// ----------------------------------------------------------------------------
// channel | direction | handshake          | beat
// in      | input     | in_valid_i/stall   | obj_a, obj_b, tag, last_item
// out     | output    | out_valid_o/stall  | status or front entry
// cfg     | input     | cfg_valid_i/ready  | register index and data
// The dominance scan and the compaction pass each read the archive memory once
// per entry. A dominated candidate leaves the scan early. A last candidate
// then dumps the front, reading each entry and emitting it before the next.
// Reset empties the archive and clears both maximize bits.
// A two-beat queue lets the input side run ahead while results are stalled.
module pareto_front_archive_core #(
  parameter int unsigned Capacity = pfa_pkg::Capacity,
  parameter int unsigned ObjWidth = pfa_pkg::ObjWidth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic [pfa_pkg::FieldWidth-1:0] obj_a_i,
  input  logic [pfa_pkg::FieldWidth-1:0] obj_b_i,
  input  logic [pfa_pkg::TagWidth-1:0] tag_i,
  input  logic last_item_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic kind_o,
  output logic accepted_o,
  output logic overflow_o,
  output logic [pfa_pkg::CountWidth-1:0] front_count_o,
  output logic [pfa_pkg::FieldWidth-1:0] entry_obj_a_o,
  output logic [pfa_pkg::FieldWidth-1:0] entry_obj_b_o,
  output logic [pfa_pkg::TagWidth-1:0] entry_tag_o,
  output logic last_of_run_o,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [0:0] cfg_index_i,
  input  logic cfg_data_i
);
  logic max_a_q, max_b_q;
  logic q_valid, q_pop;
  pfa_pkg::cand_t q_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_a_q <= 1'b0;
      max_b_q <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == pfa_pkg::RegMaximizeA) max_a_q <= cfg_data_i;
      if (cfg_index_i == pfa_pkg::RegMaximizeB) max_b_q <= cfg_data_i;
    end
  end

  pfa_front #(.ObjWidth(ObjWidth)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .obj_a_i, .obj_b_i, .tag_i,
    .last_item_i, .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  pfa_back #(.Capacity(Capacity)) u_back (
    .clk_i, .rst_ni, .max_a_i(max_a_q), .max_b_i(max_b_q),
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .out_valid_o, .out_stall_i, .kind_o, .accepted_o, .overflow_o,
    .front_count_o, .entry_obj_a_o, .entry_obj_b_o, .entry_tag_o, .last_of_run_o
  );
endmodule

// File: sim/pareto_front_archive_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pareto front archive core testbench
// Candidates are driven with random gaps. Statuses and front dumps are
// predicted per beat and checked field by field. Random output stalls are
// included. Runs cover all four maximize settings.
// ----------------------------------------------------------------------------
module pareto_front_archive_core_test;

  typedef struct packed {
    logic kind;
    logic accepted;
    logic overflow;
    logic [pfa_pkg::CountWidth-1:0] front_count;
    logic [pfa_pkg::FieldWidth-1:0] entry_obj_a;
    logic [pfa_pkg::FieldWidth-1:0] entry_obj_b;
    logic [pfa_pkg::TagWidth-1:0] entry_tag;
    logic last_of_run;
  } result_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o;
  logic [pfa_pkg::FieldWidth-1:0] obj_a_i, obj_b_i;
  logic [pfa_pkg::TagWidth-1:0] tag_i;
  logic last_item_i;
  logic out_valid_o, out_stall_i;
  logic kind_o, accepted_o, overflow_o, last_of_run_o;
  logic [pfa_pkg::CountWidth-1:0] front_count_o;
  logic [pfa_pkg::FieldWidth-1:0] entry_obj_a_o, entry_obj_b_o;
  logic [pfa_pkg::TagWidth-1:0] entry_tag_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [0:0] cfg_index_i;
  logic cfg_data_i;

  pareto_front_archive_core dut (.*);

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // Predictor state
  logic [pfa_pkg::FieldWidth-1:0] arch_a[pfa_pkg::Capacity];
  logic [pfa_pkg::FieldWidth-1:0] arch_b[pfa_pkg::Capacity];
  logic [pfa_pkg::TagWidth-1:0] arch_tag[pfa_pkg::Capacity];
  int unsigned arch_count;
  logic max_a, max_b;

  pfa_pkg::cand_t pending_cands[$];
  result_t expected_results[$];
  int errors;
  bit quiet;         // no idling near the end
  int hold_cycles;   // long receiver hold-off

  function automatic bit beats(logic [pfa_pkg::FieldWidth-1:0] x,
                               logic [pfa_pkg::FieldWidth-1:0] y, logic mx);
    return mx ? (x > y) : (x < y);
  endfunction

  function automatic bit dominates(logic [pfa_pkg::FieldWidth-1:0] xa,
                                   logic [pfa_pkg::FieldWidth-1:0] xb,
                                   logic [pfa_pkg::FieldWidth-1:0] ya,
                                   logic [pfa_pkg::FieldWidth-1:0] yb);
    return beats(xa, ya, max_a) && beats(xb, yb, max_b);
  endfunction

  task automatic archive_insert(input pfa_pkg::cand_t c);
    bit beaten;
    int unsigned keep;
    result_t r;
    beaten = 0;
    for (int i = 0; i < arch_count; i++)
      if (dominates(arch_a[i], arch_b[i], c.obj_a, c.obj_b)) beaten = 1;
    r = '0;
    if (!beaten) begin
      keep = 0;
      for (int i = 0; i < arch_count; i++)
        if (!dominates(c.obj_a, c.obj_b, arch_a[i], arch_b[i])) begin
          arch_a[keep] = arch_a[i];
          arch_b[keep] = arch_b[i];
          arch_tag[keep] = arch_tag[i];
          keep++;
        end
      arch_count = keep;
      if (arch_count < pfa_pkg::Capacity) begin
        arch_a[arch_count] = c.obj_a;
        arch_b[arch_count] = c.obj_b;
        arch_tag[arch_count] = c.tag;
        arch_count++;
        r.accepted = 1'b1;
      end else begin
        r.overflow = 1'b1;
      end
    end
    r.kind = pfa_pkg::KindStatus;
    r.front_count = pfa_pkg::CountWidth'(arch_count);
    r.last_of_run = !c.last_item || arch_count == 0;
    expected_results.insert(expected_results.size(), r);
    if (c.last_item) begin
      for (int i = 0; i < arch_count; i++) begin
        r = '0;
        r.kind = pfa_pkg::KindEntry;
        r.front_count = pfa_pkg::CountWidth'(arch_count);
        r.entry_obj_a = arch_a[i];
        r.entry_obj_b = arch_b[i];
        r.entry_tag = arch_tag[i];
        r.last_of_run = (i + 1 == arch_count);
        expected_results.insert(expected_results.size(), r);
      end
      arch_count = 0;
    end
  endtask

  // Driver
  int send_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        archive_insert({obj_a_i, obj_b_i, tag_i, last_item_i});
        void'(pending_cands.pop_front());
      end
      if (in_valid_i && in_stall_o) begin
        // hold the stalled beat
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        send_gap <= $urandom_range(0, 5);
        in_valid_i <= 1'b0;
      end else if (pending_cands.size() > (in_valid_i && !in_stall_o ? 0 : 0)) begin
        in_valid_i <= 1'b1;
        {obj_a_i, obj_b_i, tag_i, last_item_i} <= pending_cands[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor
  int stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        result_t got, exp_r;
        got = {kind_o, accepted_o, overflow_o, front_count_o, entry_obj_a_o,
               entry_obj_b_o, entry_tag_o, last_of_run_o};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.kind !== exp_r.kind) begin
            $display("%0t: kind exp %h got %h", $time, exp_r.kind, got.kind); errors++;
          end
          if (got.accepted !== exp_r.accepted) begin
            $display("%0t: accepted exp %h got %h", $time, exp_r.accepted, got.accepted);
            errors++;
          end
          if (got.overflow !== exp_r.overflow) begin
            $display("%0t: overflow exp %h got %h", $time, exp_r.overflow, got.overflow);
            errors++;
          end
          if (got.front_count !== exp_r.front_count) begin
            $display("%0t: front_count exp %0d got %0d", $time, exp_r.front_count,
                     got.front_count);
            errors++;
          end
          if (got.entry_obj_a !== exp_r.entry_obj_a) begin
            $display("%0t: entry_obj_a exp %h got %h", $time, exp_r.entry_obj_a,
                     got.entry_obj_a);
            errors++;
          end
          if (got.entry_obj_b !== exp_r.entry_obj_b) begin
            $display("%0t: entry_obj_b exp %h got %h", $time, exp_r.entry_obj_b,
                     got.entry_obj_b);
            errors++;
          end
          if (got.entry_tag !== exp_r.entry_tag) begin
            $display("%0t: entry_tag exp %h got %h", $time, exp_r.entry_tag, got.entry_tag);
            errors++;
          end
          if (got.last_of_run !== exp_r.last_of_run) begin
            $display("%0t: last_of_run exp %h got %h", $time, exp_r.last_of_run,
                     got.last_of_run);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 5);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Long hold-off counter
  always @(posedge clk_i) if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;

  task automatic add_cand(logic [31:0] a, logic [31:0] b, logic last);
    pfa_pkg::cand_t c;
    c = {a, b, 16'($urandom), last};
    pending_cands.insert(pending_cands.size(), c);
  endtask

  task automatic drain();
    wait (pending_cands.size() == 0 && !in_valid_i);
    wait (expected_results.size() == 0);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Random run: well-formed fronts with a last item, or occasional noise
  task automatic random_run();
    int n;
    logic [31:0] base;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 45) : $urandom_range(1, 10);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: add_cand($urandom, $urandom, 1'b0);
        1: add_cand($urandom_range(0, 15), $urandom_range(0, 15), 1'b0);
        2: begin
          base = $urandom_range(0, 1000);
          add_cand(base, 1000 - base, 1'b0);
        end
        default: add_cand(32'hFFFF_FFF0 + $urandom_range(0, 15), $urandom_range(0, 15), 1'b0);
      endcase
    end
    add_cand($urandom, $urandom, 1'b1);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = pfa_pkg::RegMaximizeA;
    cfg_data_i = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    obj_a_i = '0; obj_b_i = '0; tag_i = '0; last_item_i = 1'b0;
    arch_count = 0; max_a = 0; max_b = 0;
    errors = 0; quiet = 0; hold_cycles = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single-entry dump, extremes, equal points, domination, full archive
    add_cand(32'h0, 32'h0, 1'b1);
    add_cand(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_cand(32'h0, 32'hFFFF_FFFF, 1'b0);
    add_cand(32'h0, 32'hFFFF_FFFF, 1'b0);
    add_cand(32'h10, 32'h10, 1'b0);
    add_cand(32'h20, 32'h20, 1'b0);
    add_cand(32'h0, 32'h0, 1'b1);
    for (int i = 0; i < 34; i++) add_cand(i, 100 - i, 1'b0);
    add_cand(0, 0, 1'b0);
    add_cand(5, 200, 1'b1);
    drain();

    // Long receiver hold-off while the sender keeps offering
    hold_cycles = 400;
    for (int i = 0; i < 8; i++) add_cand($urandom, $urandom, i == 7);
    drain();

    for (int s = 0; s < 4; s++) begin
      write_reg(pfa_pkg::RegMaximizeA, s[0]);
      write_reg(pfa_pkg::RegMaximizeB, s[1]);
      max_a = s[0]; max_b = s[1];
      add_cand(32'h0, 32'h0, 1'b0);
      add_cand(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      add_cand(32'h5, 32'h5, 1'b1);
      while (pending_cands.size() < 90) random_run();
      if (s == 3) quiet = 1;
      drain();
    end

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: files.f
hdl/pfa_pkg.sv
hdl/pfa_front.sv
hdl/pfa_back.sv
hdl/pareto_front_archive_core.sv
sim/pareto_front_archive_core_test.sv
